// ===== src/cue_pkg.sv =====
// Shared package of the unified CORDIC engine: field widths, register and
// mode codes, the sequencer control struct and the elaboration-time table
// builders. No dependencies.
package cue_pkg;

    localparam int FIELD_W = 32;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int TABLE_DEPTH_DEF   = 32;

    localparam logic [IDX_W-1:0] ITER_MAX  = 6'd32;
    localparam logic [IDX_W-1:0] ITER_RST  = 6'd24;
    localparam logic [IDX_W-1:0] HYP_REP_A = 6'd4;
    localparam logic [IDX_W-1:0] HYP_REP_B = 6'd13;

    localparam logic [1:0] COORD_CIRC = 2'd0;
    localparam logic [1:0] COORD_LIN  = 2'd1;
    localparam logic [1:0] COORD_HYP  = 2'd2;

    localparam logic MODE_ROT = 1'b0;
    localparam logic MODE_VEC = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    typedef struct packed {
        logic             ready;
        logic             load;
        logic             step;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } cue_ctrl_t;

    // Restoring division, used only while the tables are built.
    function automatic logic [63:0] cue_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Series for atan (alternating) or atanh of 2^-i in Q2.62.
    function automatic logic [63:0] cue_pow2_series(input int i, input logic alternate);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        if (i != 0)
        begin
            for (int k = 0; k < 64; k++)
            begin
                e = i * (2 * k + 1);
                if (e <= 62)
                begin
                    term = cue_udiv(64'd1 << (62 - e), 64'(2 * k + 1));
                    if (alternate && k[0])
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // atan(1/n) in Q2.62.
    function automatic logic [63:0] cue_recip_atan(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        p   = cue_udiv(Q62_ONE, n);
        sum = '0;
        k   = 0;
        while (p != 64'd0)
        begin
            term = cue_udiv(p, 64'(2 * k + 1));
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
            p = cue_udiv(p, n * n);
            k = k + 1;
        end
        return sum;
    endfunction

    // Q8.56 value rounded half up to fb fraction bits and wrapped to dw bits.
    function automatic logic [63:0] cue_to_frac(input logic [63:0] v56, input int fb,
                                                input int dw);
        logic [63:0] mask;
        logic [63:0] res;
        int          sh;
        mask = (64'd1 << dw) - 64'd1;
        if (fb >= 56)
            res = (v56 << (fb - 56)) & mask;
        else
        begin
            sh  = 56 - fb;
            res = ((v56 + (64'd1 << (sh - 1))) >> sh) & mask;
        end
        return res;
    endfunction

    // Table entry i of the given coordinate system.
    function automatic logic [63:0] cue_table_entry(input logic [1:0] kind, input int i,
                                                    input int fb, input int dw);
        logic [63:0] qpi;
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] deg56;
        logic [63:0] mask;
        logic [63:0] res;
        mask = (64'd1 << dw) - 64'd1;
        res  = '0;
        if (kind == COORD_CIRC)
        begin
            qpi = 64'd4 * cue_recip_atan(64'd5) - cue_recip_atan(64'd239);
            a   = (i == 0) ? qpi : cue_pow2_series(i, 1'b1);
            r   = a;
            q   = '0;
            if (r >= qpi)
            begin
                q = 64'd1;
                r = r - qpi;
            end
            for (int b = 0; b < 62; b++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= qpi)
                begin
                    r    = r - qpi;
                    q[0] = 1'b1;
                end
            end
            deg56 = 64'd45 * (q >> 6) + ((64'd45 * (q & 64'd63)) >> 6);
            res   = cue_to_frac(deg56, fb, dw);
        end
        else if (kind == COORD_LIN)
        begin
            if (i <= fb)
                res = (64'd1 << (fb - i)) & mask;
        end
        else if (i != 0)
            res = cue_to_frac(cue_pow2_series(i, 1'b0) >> 6, fb, dw);
        return res;
    endfunction

endpackage

// ===== src/cue_if.sv =====
// Valid/ready channel interfaces for the input and result items of the
// unified CORDIC engine. Depends on cue_pkg.
interface cue_in_if
    import cue_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  x_start;
    logic signed [FIELD_W-1:0]  y_start;
    logic signed [FIELD_W-1:0]  z_start;

    modport source (output valid, output x_start, output y_start, output z_start,
                    input ready);
    modport sink   (input valid, input x_start, input y_start, input z_start,
                    output ready);
endinterface

interface cue_out_if
    import cue_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  x_result;
    logic signed [FIELD_W-1:0]  y_result;
    logic signed [FIELD_W-1:0]  z_result;

    modport source (output valid, output x_result, output y_result, output z_result,
                    input ready);
    modport sink   (input valid, input x_result, input y_result, input z_result,
                    output ready);
endinterface

// ===== src/cue_seq.sv =====
// Iteration sequencer of the unified CORDIC engine: counts micro-rotations,
// steps the table index and schedules the hyperbolic repeats. Uses cue_pkg.
module cue_seq
    import cue_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       coord,
    input  logic [IDX_W-1:0] count,
    input  logic             out_free,
    output cue_ctrl_t        ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic             rep_reg, rep_next;
    logic             hyp_reg, hyp_next;
    logic [IDX_W-1:0] n_eff;
    logic             repeat_now;

    assign n_eff = (count > ITER_MAX) ? ITER_MAX : count;

    // Hyperbolic indices four and thirteen are run twice; the first pass
    // does not advance the index or the count.
    assign repeat_now = hyp_reg && !rep_reg && (idx_reg == HYP_REP_A || idx_reg == HYP_REP_B);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        rep_next   = rep_reg;
        hyp_next   = hyp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = (coord == COORD_CIRC) ? 6'd0 : 6'd1;
                    cnt_next   = '0;
                    rep_next   = 1'b0;
                    n_next     = n_eff;
                    hyp_next   = (coord != COORD_CIRC) && (coord != COORD_LIN);
                    state_next = (n_eff == 6'd0) ? S_HOLD : S_RUN;
                end
            end
            S_RUN:
            begin
                if (repeat_now)
                    rep_next = 1'b1;
                else
                begin
                    rep_next = 1'b0;
                    idx_next = IDX_W'(idx_reg + 6'd1);
                    cnt_next = IDX_W'(cnt_reg + 6'd1);
                    if (IDX_W'(cnt_reg + 6'd1) == n_reg)
                        state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            rep_reg   <= 1'b0;
            hyp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            rep_reg   <= rep_next;
            hyp_reg   <= hyp_next;
        end
    end

    always_comb
    begin
        ctrl.ready  = (state_reg == S_IDLE);
        ctrl.load   = start && (state_reg == S_IDLE);
        ctrl.step   = (state_reg == S_RUN);
        ctrl.finish = (state_reg == S_HOLD) && out_free;
        ctrl.idx    = idx_reg;
    end

endmodule

// ===== src/cue_datapath.sv =====
// Shared shift-add unit of the unified CORDIC engine: the x, y, z working
// registers, the barrel shifters and the constant angle tables. Uses cue_pkg.
module cue_datapath
    import cue_pkg::*;
#(
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  cue_ctrl_t             ctrl,
    input  logic [1:0]            coord,
    input  logic                  mode,
    input  logic [DATA_WIDTH-1:0] x_in,
    input  logic [DATA_WIDTH-1:0] y_in,
    input  logic [DATA_WIDTH-1:0] z_in,
    output logic [DATA_WIDTH-1:0] x_out,
    output logic [DATA_WIDTH-1:0] y_out,
    output logic [DATA_WIDTH-1:0] z_out
);

    localparam int TAB_IW = $clog2(TABLE_DEPTH);

    logic [DATA_WIDTH-1:0] circ_rom [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] lin_rom  [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] hyp_rom  [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_tab
        localparam logic [63:0] CIRC_E = cue_table_entry(COORD_CIRC, g, FRACTION_BITS, DATA_WIDTH);
        localparam logic [63:0] LIN_E  = cue_table_entry(COORD_LIN, g, FRACTION_BITS, DATA_WIDTH);
        localparam logic [63:0] HYP_E  = cue_table_entry(COORD_HYP, g, FRACTION_BITS, DATA_WIDTH);
        assign circ_rom[g] = CIRC_E[DATA_WIDTH-1:0];
        assign lin_rom[g]  = LIN_E[DATA_WIDTH-1:0];
        assign hyp_rom[g]  = HYP_E[DATA_WIDTH-1:0];
    end

    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] z_reg, z_next;
    logic [DATA_WIDTH-1:0] dx;
    logic [DATA_WIDTH-1:0] dy;
    logic [DATA_WIDTH-1:0] t;
    logic [TAB_IW-1:0]     tab_addr;
    logic                  up;
    logic                  x_sub;

    assign tab_addr = ctrl.idx[TAB_IW-1:0];

    always_comb
    begin
        t = '0;
        if (ctrl.idx < IDX_W'(TABLE_DEPTH) || TABLE_DEPTH >= (1 << IDX_W))
        begin
            unique case (coord)
                COORD_CIRC: t = circ_rom[tab_addr];
                COORD_LIN:  t = lin_rom[tab_addr];
                default:    t = hyp_rom[tab_addr];
            endcase
        end
    end

    // Shifts of the full width or more leave copies of the sign bit.
    assign dx = DATA_WIDTH'($signed(y_reg) >>> ctrl.idx);
    assign dy = DATA_WIDTH'($signed(x_reg) >>> ctrl.idx);

    // Vectoring turns against the sign product of x and y, zero counted as
    // positive; rotation follows the sign of z.
    assign up    = (mode == MODE_VEC) ? (x_reg[DATA_WIDTH-1] != y_reg[DATA_WIDTH-1])
                                      : !z_reg[DATA_WIDTH-1];
    assign x_sub = ((coord == COORD_CIRC) == up);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctrl.load)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (ctrl.step)
        begin
            if (coord != COORD_LIN)
                x_next = x_sub ? (x_reg - dx) : (x_reg + dx);
            y_next = up ? (y_reg + dy) : (y_reg - dy);
            z_next = up ? (z_reg - t) : (z_reg + t);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== src/unified_cordic_engine_top.sv =====
// Top level of the unified CORDIC engine: configuration registers, sequencer,
// shift-add datapath and the result register. Uses cue_pkg and cue_if.
//
// Usage: a triple (x_start, y_start, z_start) enters on in_item and the
// rotated triple leaves on out_item, both valid/ready channels where an item
// moves at a clock edge with valid and ready high. Registers are written on
// cfg_we with cfg_index 0 (coordinate system), 1 (rotation or vectoring) and
// 2 (iteration count); the user must write them only while no item is in
// flight, and the block itself does not enforce this. With n the iteration
// count (capped at 32) and r the hyperbolic repeats reached (0, 1 or 2), an
// item takes n + r micro-rotations, one per cycle by the single shift-add
// unit, and the next item is taken only after its result has gone to the
// output register; in_item.ready is high only while the sequencer is idle.
// Reset clears the registers to circular rotation with 24 iterations and
// leaves both channels empty. When the receiver stalls the result waits in
// the output register; the next item is still accepted and worked on, and it
// waits in the datapath until the output register is free.
module unified_cordic_engine_top
    import cue_pkg::*;
#(
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    cue_in_if.sink               in_item,
    cue_out_if.source            out_item
);

    logic [1:0]            coord_reg;
    logic                  mode_reg;
    logic [IDX_W-1:0]      count_reg;
    cue_ctrl_t             ctrl;
    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    x_res_reg;
    logic [FIELD_W-1:0]    y_res_reg;
    logic [FIELD_W-1:0]    z_res_reg;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] x_in;
    logic [DATA_WIDTH-1:0] y_in;
    logic [DATA_WIDTH-1:0] z_in;
    logic [DATA_WIDTH-1:0] x_dp;
    logic [DATA_WIDTH-1:0] y_dp;
    logic [DATA_WIDTH-1:0] z_dp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg <= COORD_CIRC;
            mode_reg  <= MODE_ROT;
            count_reg <= ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COORD: coord_reg <= cfg_data[1:0];
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_COUNT: count_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_item.ready;

    cue_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_item.valid),
        .coord    (coord_reg),
        .count    (count_reg),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Inputs are sign-extended or wrapped to the working width.
    assign x_in = DATA_WIDTH'(in_item.x_start);
    assign y_in = DATA_WIDTH'(in_item.y_start);
    assign z_in = DATA_WIDTH'(in_item.z_start);

    cue_datapath #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .TABLE_DEPTH   (TABLE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .ctrl  (ctrl),
        .coord (coord_reg),
        .mode  (mode_reg),
        .x_in  (x_in),
        .y_in  (y_in),
        .z_in  (z_in),
        .x_out (x_dp),
        .y_out (y_dp),
        .z_out (z_dp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.finish)
            out_valid_reg <= 1'b1;
        else if (out_item.ready)
            out_valid_reg <= 1'b0;
    end

    // Results keep the low bits of the working value, zero-filled if narrower.
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            x_res_reg <= FIELD_W'(x_dp);
            y_res_reg <= FIELD_W'(y_dp);
            z_res_reg <= FIELD_W'(z_dp);
        end
    end

    assign in_item.ready     = ctrl.ready;
    assign out_item.valid    = out_valid_reg;
    assign out_item.x_result = x_res_reg;
    assign out_item.y_result = y_res_reg;
    assign out_item.z_result = z_res_reg;

endmodule

// ===== src/cue_checker.sv =====
// Port-level checks for the unified CORDIC engine, attached to the top level
// by the bind statement at the end. Uses cue_pkg.
module cue_checker
    import cue_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] x_result,
    input logic [FIELD_W-1:0] y_result,
    input logic [FIELD_W-1:0] z_result
);

    // The engine works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item was in flight");

    // A fresh result only appears after the engine has been busy.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item being worked on");

    // Even with no iterations the result is registered only after the input
    // edge, by way of the hold state, never at the input edge itself.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result became valid at the edge that took its input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_result)
            && $stable(y_result) && $stable(z_result))
        else $error("stalled result changed or was dropped");

endmodule

bind unified_cordic_engine_top cue_checker u_cue_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .x_result  (out_item.x_result),
    .y_result  (out_item.y_result),
    .z_result  (out_item.z_result)
);

// ===== sim/cue_result_checker.sv =====
// Result checker for the unified CORDIC engine: watches the register port and
// both item channels, predicts each result triple and compares it on arrival.
// Depends on cue_pkg and the channel interfaces in cue_if.
module cue_result_checker
    import cue_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    cue_in_if                    in_mon,
    cue_out_if                   out_mon,
    output int                   failures,
    output int                   pending
);

    localparam int FB         = FRACTION_BITS_DEF;
    localparam int LUT_DEPTH  = TABLE_DEPTH_DEF;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
    } cue_triple_t;

    logic [FIELD_W-1:0] atan_deg_lut [LUT_DEPTH];
    logic [FIELD_W-1:0] atanh_lut    [LUT_DEPTH];
    logic [FIELD_W-1:0] inv_pow2_lut [LUT_DEPTH];

    logic [1:0]       coord_q;
    logic             mode_q;
    logic [IDX_W-1:0] count_q;

    cue_triple_t expected_triples [$];

    // Power series of atan (alternating signs) or atanh of 2^-i in Q2.62.
    function automatic bit [63:0] pow2_series(int i, bit alt);
        bit [63:0] acc;
        bit [63:0] term;
        int        e;
        acc = '0;
        for (int k = 0; k < 64; k++)
        begin
            e = i * (2 * k + 1);
            if (e > 62)
                break;
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            if (alt && k[0])
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    // atan(1/n) in Q2.62, for the Machin form of a quarter turn.
    function automatic bit [63:0] arctan_recip(bit [63:0] n);
        bit [63:0] p;
        bit [63:0] acc;
        int        k;
        p   = (64'd1 << 62) / n;
        acc = '0;
        k   = 0;
        while (p != 64'd0)
        begin
            if (k[0])
                acc = acc - p / 64'(2 * k + 1);
            else
                acc = acc + p / 64'(2 * k + 1);
            p = p / (n * n);
            k++;
        end
        return acc;
    endfunction

    // Q8.56 rounded half up to the field's fraction bits.
    function automatic logic [FIELD_W-1:0] round_to_field(bit [63:0] v56);
        return FIELD_W'((v56 + (64'd1 << (55 - FB))) >> (56 - FB));
    endfunction

    initial
    begin
        bit [63:0] qpi;
        bit [63:0] rem;
        bit [63:0] quo;
        bit [63:0] deg;
        qpi = 64'd4 * arctan_recip(64'd5) - arctan_recip(64'd239);
        for (int i = 0; i < LUT_DEPTH; i++)
        begin
            // Degrees are 45 times the angle divided by a quarter turn, done
            // as a long division to 62 binary places.
            rem = (i == 0) ? qpi : pow2_series(i, 1'b1);
            quo = '0;
            if (rem >= qpi)
            begin
                quo = 64'd1;
                rem = rem - qpi;
            end
            for (int b = 0; b < 62; b++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= qpi)
                begin
                    rem    = rem - qpi;
                    quo[0] = 1'b1;
                end
            end
            deg = 64'd45 * (quo >> 6) + ((64'd45 * (quo & 64'd63)) >> 6);
            atan_deg_lut[i] = round_to_field(deg);
            atanh_lut[i]    = (i == 0) ? '0 : round_to_field(pow2_series(i, 1'b0) >> 6);
            inv_pow2_lut[i] = (i <= FB) ? FIELD_W'(64'd1 << (FB - i)) : '0;
        end
    end

    function automatic cue_triple_t cordic_rotate(cue_triple_t start);
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        logic [FIELD_W-1:0] dx;
        logic [FIELD_W-1:0] dy;
        logic [FIELD_W-1:0] term;
        logic               circ;
        logic               lin;
        logic               up;
        int                 n;
        int                 idx;
        int                 reps;
        cue_triple_t        res;
        x    = start.x;
        y    = start.y;
        z    = start.z;
        circ = (coord_q == COORD_CIRC);
        lin  = (coord_q == COORD_LIN);
        n    = (count_q > ITER_MAX) ? int'(ITER_MAX) : int'(count_q);
        idx  = circ ? 0 : 1;
        for (int done = 0; done < n; done++)
        begin
            // Hyperbolic mode runs two of its indices twice to converge.
            reps = (!circ && !lin && (idx == HYP_REP_A || idx == HYP_REP_B)) ? 2 : 1;
            repeat (reps)
            begin
                dx = (idx >= FIELD_W) ? {FIELD_W{y[FIELD_W-1]}} : FIELD_W'($signed(y) >>> idx);
                dy = (idx >= FIELD_W) ? {FIELD_W{x[FIELD_W-1]}} : FIELD_W'($signed(x) >>> idx);
                if (idx >= LUT_DEPTH)
                    term = '0;
                else if (circ)
                    term = atan_deg_lut[idx];
                else if (lin)
                    term = inv_pow2_lut[idx];
                else
                    term = atanh_lut[idx];
                if (mode_q == MODE_VEC)
                    up = (x[FIELD_W-1] != y[FIELD_W-1]);
                else
                    up = !z[FIELD_W-1];
                if (up)
                begin
                    if (circ)
                        x = x - dx;
                    else if (!lin)
                        x = x + dx;
                    y = y + dy;
                    z = z - term;
                end
                else
                begin
                    if (circ)
                        x = x + dx;
                    else if (!lin)
                        x = x - dx;
                    y = y - dy;
                    z = z + term;
                end
            end
            idx++;
        end
        res.x = x;
        res.y = y;
        res.z = z;
        return res;
    endfunction

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cue_triple_t item;
        cue_triple_t want;
        if (!rst_n)
        begin
            coord_q  = COORD_CIRC;
            mode_q   = MODE_ROT;
            count_q  = ITER_RST;
            failures = 0;
            expected_triples.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COORD: coord_q = cfg_data[1:0];
                    REG_MODE:  mode_q  = cfg_data[0];
                    REG_COUNT: count_q = cfg_data[IDX_W-1:0];
                    default:   ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
            begin
                item.x = in_mon.x_start;
                item.y = in_mon.y_start;
                item.z = in_mon.z_start;
                expected_triples.push_back(cordic_rotate(item));
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_triples.size() == 0)
                begin
                    $error("result item with no triple outstanding: %h %h %h",
                           out_mon.x_result, out_mon.y_result, out_mon.z_result);
                    failures++;
                end
                else
                begin
                    want = expected_triples.pop_front();
                    check_field("x_result", want.x, out_mon.x_result);
                    check_field("y_result", want.y, out_mon.y_result);
                    check_field("z_result", want.z, out_mon.z_result);
                end
            end
        end
        pending = expected_triples.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the unified CORDIC engine: clock, reset, register writes,
// input items and receiver back-pressure, plus the verdict and a watchdog.
// Depends on cue_pkg, cue_if, the engine RTL and cue_result_checker.
module tb_top;
    import cue_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SEGMENTS    = 7;
    localparam int SEG_ITEMS   = 40;

    // Index three selects no register and the top coordinate code aliases
    // hyperbolic; both are exercised on purpose.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam logic [1:0]           COORD_SPARE = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   failures;
    int                   pending;
    int                   src_idle_pct;
    int                   snk_idle_pct;

    cue_in_if  in_item();
    cue_out_if out_item();

    unified_cordic_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_item  (out_item)
    );

    cue_result_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_item),
        .out_mon   (out_item),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        out_item.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_item.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Mostly small Q8.24 values, with angles in range, corner codes and raw words.
    function automatic logic [FIELD_W-1:0] pick_q824();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:
            begin
                case ($urandom_range(4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0100_0000;
                endcase
            end
            3, 4:    return $urandom_range(0, 32'hC800_0000) - 32'h6400_0000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a following item keeps the channel busy.
    task automatic push_triple(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                               logic [FIELD_W-1:0] z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_item.valid <= 1'b0;
            @(negedge clk);
        end
        in_item.valid   <= 1'b1;
        in_item.x_start <= x;
        in_item.y_start <= y;
        in_item.z_start <= z;
        do
            @(posedge clk);
        while (!in_item.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_item.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Unused upper data bits carry noise; the registers keep only their width.
    task automatic program_regs(logic [1:0] coord, logic mode, logic [IDX_W-1:0] count);
        wait_drained();
        write_reg(REG_COORD, {4'($urandom_range(15)), coord});
        write_reg(REG_MODE, {5'($urandom_range(31)), mode});
        write_reg(REG_COUNT, count);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [1:0]       coord;
        logic             mode;
        logic [IDX_W-1:0] count;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_COORD;
        cfg_data        = '0;
        in_item.valid   = 1'b0;
        in_item.x_start = '0;
        in_item.y_start = '0;
        in_item.z_start = '0;
        src_idle_pct    = 0;
        snk_idle_pct    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setting: circular rotation over 24 iterations.
        push_triple(32'h0100_0000, 32'h0000_0000, 32'h1E00_0000);
        push_triple(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_triple(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_triple(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        program_regs(COORD_CIRC, MODE_VEC, ITER_MAX);
        push_triple(32'h0100_0000, 32'h0100_0000, 32'h0000_0000);
        push_triple(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        push_triple(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);

        // Linear runs to index 32, beyond the end of the table.
        program_regs(COORD_LIN, MODE_ROT, ITER_MAX);
        push_triple(32'h0200_0000, 32'h0000_0000, 32'h0180_0000);
        push_triple(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);

        program_regs(COORD_LIN, MODE_VEC, 6'd1);
        push_triple(32'h0100_0000, 32'h0080_0000, 32'h0000_0000);
        push_triple(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        program_regs(COORD_HYP, MODE_ROT, 6'd16);
        push_triple(32'h0100_0000, 32'h0000_0000, 32'h0080_0000);
        push_triple(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);

        program_regs(COORD_HYP, MODE_VEC, ITER_MAX);
        push_triple(32'h0200_0000, 32'h0100_0000, 32'h0000_0000);
        push_triple(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);

        program_regs(COORD_SPARE, MODE_ROT, HYP_REP_B);
        push_triple(32'h0100_0000, 32'h0040_0000, 32'h0020_0000);

        // No micro-rotation at all: the triple passes through unchanged.
        program_regs(COORD_CIRC, MODE_ROT, 6'd0);
        push_triple(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);

        // A count above the maximum saturates.
        program_regs(COORD_HYP, MODE_VEC, 6'd63);
        push_triple(32'h0100_0000, 32'hFF80_0000, 32'h0000_0001);

        // A write to the spare index must leave every register alone.
        program_regs(COORD_LIN, MODE_ROT, ITER_RST);
        @(negedge clk);
        write_reg(REG_SPARE, 6'($urandom_range(63)));
        cfg_we <= 1'b0;
        push_triple(32'h0300_0000, 32'hFE00_0000, 32'hFF40_0000);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 67 : 0;
            snk_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 22 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                coord = 2'($urandom_range(3));
                mode  = 1'($urandom_range(1));
                case ($urandom_range(7))
                    0:       count = 6'd1;
                    1:       count = ITER_MAX;
                    2:       count = $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63));
                    default: count = 6'($urandom_range(1, 32));
                endcase
                program_regs(coord, mode, count);
                for (int k = 0; k < SEG_ITEMS; k++)
                begin
                    if ($urandom_range(59) == 0)
                        wait_drained();
                    push_triple(pick_q824(), pick_q824(), pick_q824());
                end
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
